### rtl/efc_pkg.sv
`timescale 1ns / 1ps
// Shared widths, types and constants for the electric field constraint core.
package efc_pkg;

	localparam int W    = 32;
	localparam int CW   = 2 * W + 1;
	localparam int NW   = 3 * W + 1;
	localparam int BBW  = 2 * W;
	localparam int D2W  = 4 * W;
	localparam int MW   = 3 * W + 1;
	localparam int PW   = 2 * MW;
	localparam int RW   = 6 * W + 8;
	localparam int PWD  = 5 * W + 4;
	localparam int QW   = W + 2;
	localparam int K    = W + 2;
	localparam int KB   = $clog2(K);
	localparam int CH   = 32;
	localparam int NCH  = (MW + CH - 1) / CH;
	localparam int AW   = 2 * NCH * CH;
	localparam int LM   = 5;

	typedef logic signed [W-1:0]   comp_t;
	typedef logic signed [MW-1:0]  mop_t;
	typedef logic signed [PW-1:0]  mprod_t;
	typedef logic signed [CW-1:0]  cross_t;
	typedef logic signed [NW-1:0]  nvec_t;
	typedef logic [BBW-1:0]        bb_t;
	typedef logic [D2W-1:0]        d2_t;

	typedef struct packed {
		logic signed [RW-1:0]  r;
		logic signed [PWD-1:0] p;
		logic [QW-1:0]         q;
	} lane_t;

endpackage

### rtl/efc_mul.sv
`timescale 1ns / 1ps
// Pipelined signed multiplier built from 32 x 32-bit partial products.
module efc_mul (
	input  logic                 clk,
	input  efc_pkg::mop_t        a,
	input  efc_pkg::mop_t        b,
	output efc_pkg::mprod_t      p
);
	import efc_pkg::*;

	logic [MW-1:0]       abs_a, abs_b;
	logic [NCH*CH-1:0]   ma_s1, mb_s1;
	logic                neg_s1, neg_s2, neg_s3, neg_s4;
	logic [2*CH-1:0]     pp_s2 [NCH][NCH];
	logic [AW-1:0]       row_c [NCH];
	logic [AW-1:0]       row_s3 [NCH];
	logic [AW-1:0]       sum_c;
	logic [AW-1:0]       sum_s4;

	always_comb begin
		abs_a = a[MW-1] ? MW'(-a) : MW'(a);
		abs_b = b[MW-1] ? MW'(-b) : MW'(b);
	end

	always_comb begin
		for (int i = 0; i < NCH; i++) begin
			row_c[i] = '0;
			for (int j = 0; j < NCH; j++) begin
				row_c[i] = row_c[i] + (AW'(pp_s2[i][j]) << (CH * j));
			end
		end
		sum_c = '0;
		for (int i = 0; i < NCH; i++) begin
			sum_c = sum_c + (row_s3[i] << (CH * i));
		end
	end

	always_ff @(posedge clk) begin
		ma_s1  <= (NCH*CH)'(abs_a);
		mb_s1  <= (NCH*CH)'(abs_b);
		neg_s1 <= a[MW-1] ^ b[MW-1];
		for (int i = 0; i < NCH; i++) begin
			for (int j = 0; j < NCH; j++) begin
				pp_s2[i][j] <= ma_s1[i*CH +: CH] * mb_s1[j*CH +: CH];
			end
		end
		neg_s2 <= neg_s1;
		row_s3 <= row_c;
		neg_s3 <= neg_s2;
		sum_s4 <= sum_c;
		neg_s4 <= neg_s3;
		p      <= neg_s4 ? -$signed(sum_s4[PW-1:0]) : $signed(sum_s4[PW-1:0]);
	end

endmodule

### rtl/efc_root_step.sv
`timescale 1ns / 1ps
// One bit of the rounded quotient by the square root of the divisor.
module efc_root_step (
	input  logic                  clk,
	input  logic [efc_pkg::KB-1:0] k,
	input  efc_pkg::d2_t          d2,
	input  efc_pkg::lane_t        lane_in,
	output efc_pkg::lane_t        lane_out
);
	import efc_pkg::*;

	logic signed [RW-1:0] p_x, d_x, trial;
	logic [KB+1:0]        sh_a, sh_b, sh_c;
	lane_t                nxt;

	always_comb begin
		sh_c  = (KB+2)'(k) + (KB+2)'(1);
		sh_a  = (KB+2)'(k) + (KB+2)'(2);
		sh_b  = ((KB+2)'(k) << 1) + (KB+2)'(2);
		p_x   = RW'(lane_in.p);
		d_x   = $signed(RW'(d2));
		trial = lane_in.r - (p_x <<< sh_a) - (d_x <<< sh_b);
		nxt   = lane_in;
		if (!trial[RW-1]) begin
			nxt.r = trial;
			nxt.p = PWD'(p_x + (d_x <<< sh_c));
			nxt.q = lane_in.q | (QW'(1) << k);
		end
	end

	always_ff @(posedge clk) begin
		lane_out <= nxt;
	end

endmodule

### rtl/electric_field_constraint_core.sv
`timescale 1ns / 1ps
// Top level: E with its part along B removed, capped to |B|, rounded and saturated.
// Pipeline: one input register, three multiply groups, 34 root stages and one
// output register, in that order; done rises together with the result.
// Throughput: one item per cycle; busy never rises, the pipeline has no stall.
// Each multiply group is the five-stage partial-product multiplier followed by a register.
// Reset clears the valid bits only; the data path holds no state between items.
module electric_field_constraint_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  efc_pkg::comp_t ex,
	input  efc_pkg::comp_t ey,
	input  efc_pkg::comp_t ez,
	input  efc_pkg::comp_t bx,
	input  efc_pkg::comp_t by,
	input  efc_pkg::comp_t bz,
	output logic           done,
	output efc_pkg::comp_t res_x,
	output efc_pkg::comp_t res_y,
	output efc_pkg::comp_t res_z
);
	import efc_pkg::*;

	localparam logic [QW-1:0] LIM = (QW'(1) << (W - 1)) - QW'(1);

	function automatic comp_t sat_out(input logic [QW-1:0] q, input logic neg,
		input logic zero);
		logic [QW-1:0] qq;
		qq = q;
		if (zero) begin
			return '0;
		end
		if (!neg) begin
			if (qq > LIM) qq = LIM;
			return comp_t'(qq);
		end
		if (qq > LIM + QW'(1)) qq = LIM + QW'(1);
		return comp_t'(QW'(0) - qq);
	endfunction

	logic          v_s0;
	comp_t         e_s0 [3];
	comp_t         b_s0 [3];

	mprod_t        pa [3], pb [3], pbb [3];
	logic [LM-1:0] v_d1;
	comp_t         b_d1 [LM][3];
	bb_t           bb_sum;
	logic          v_s1, bz_s1;
	cross_t        c_s1 [3];
	comp_t         b_s1 [3];
	bb_t           bb_s1;

	mprod_t        qa [3], qb [3], qcc [3], qbb;
	logic [LM-1:0] v_d2, bz_d2;
	d2_t           cc_sum, bb2;
	logic          v_s2, bz_s2;
	nvec_t         n_s2 [3];
	d2_t           d2_s2;

	mprod_t        msq [3];
	logic [LM-1:0] v_d3, bz_d3;
	d2_t           d2_d3 [LM];
	logic [2:0]    neg_d3 [LM];

	lane_t         lane_s3 [3];
	logic [K:0]    v_rt;
	logic          bz_rt [K+1];
	d2_t           d2_rt [K];
	logic [2:0]    neg_rt [K+1];
	lane_t         lane_rt [K+1][3];

	assign busy = 1'b0;

	always_comb begin
		bb_sum = bb_t'(pbb[0] + pbb[1] + pbb[2]);
		cc_sum = d2_t'(qcc[0] + qcc[1] + qcc[2]);
		bb2    = d2_t'(qbb);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s0 <= 1'b0;
			v_d1 <= '0;
			v_s1 <= 1'b0;
			v_d2 <= '0;
			v_s2 <= 1'b0;
			v_d3 <= '0;
			v_rt <= '0;
			done <= 1'b0;
		end else begin
			v_s0 <= start;
			v_d1 <= {v_d1[LM-2:0], v_s0};
			v_s1 <= v_d1[LM-1];
			v_d2 <= {v_d2[LM-2:0], v_s1};
			v_s2 <= v_d2[LM-1];
			v_d3 <= {v_d3[LM-2:0], v_s2};
			v_rt <= {v_rt[K-1:0], v_d3[LM-1]};
			done <= v_rt[K];
		end
	end

	always_ff @(posedge clk) begin
		e_s0[0] <= ex;
		e_s0[1] <= ey;
		e_s0[2] <= ez;
		b_s0[0] <= bx;
		b_s0[1] <= by;
		b_s0[2] <= bz;

		b_d1[0] <= b_s0;
		for (int j = 1; j < LM; j++) b_d1[j] <= b_d1[j-1];
		for (int i = 0; i < 3; i++) begin
			c_s1[i] <= cross_t'(pa[i] - pb[i]);
			b_s1[i] <= b_d1[LM-1][i];
		end
		bb_s1 <= bb_sum;
		bz_s1 <= (bb_sum == '0);

		bz_d2 <= {bz_d2[LM-2:0], bz_s1};
		for (int i = 0; i < 3; i++) n_s2[i] <= nvec_t'(qa[i] - qb[i]);
		d2_s2 <= (cc_sum > bb2) ? cc_sum : bb2;
		bz_s2 <= bz_d2[LM-1];

		bz_d3     <= {bz_d3[LM-2:0], bz_s2};
		d2_d3[0]  <= d2_s2;
		for (int i = 0; i < 3; i++) neg_d3[0][i] <= n_s2[i][NW-1];
		for (int j = 1; j < LM; j++) begin
			d2_d3[j]  <= d2_d3[j-1];
			neg_d3[j] <= neg_d3[j-1];
		end
		for (int i = 0; i < 3; i++) begin
			lane_s3[i].r <= (RW'(msq[i]) <<< 2) - $signed(RW'(d2_d3[LM-1]));
			lane_s3[i].p <= -$signed(PWD'(d2_d3[LM-1]));
			lane_s3[i].q <= '0;
		end
		d2_rt[0]  <= d2_d3[LM-1];
		neg_rt[0] <= neg_d3[LM-1];
		bz_rt[0]  <= bz_d3[LM-1];

		for (int j = 0; j < K - 1; j++) d2_rt[j+1] <= d2_rt[j];
		for (int j = 0; j < K; j++) begin
			neg_rt[j+1] <= neg_rt[j];
			bz_rt[j+1]  <= bz_rt[j];
		end

		res_x <= sat_out(lane_rt[K][0].q, neg_rt[K][0], bz_rt[K]);
		res_y <= sat_out(lane_rt[K][1].q, neg_rt[K][1], bz_rt[K]);
		res_z <= sat_out(lane_rt[K][2].q, neg_rt[K][2], bz_rt[K]);
	end

	for (genvar i = 0; i < 3; i++) begin : g_lane
		localparam int I1 = (i + 1) % 3;
		localparam int I2 = (i + 2) % 3;

		efc_mul u_pa (.clk(clk), .a(mop_t'(e_s0[I1])), .b(mop_t'(b_s0[I2])), .p(pa[i]));
		efc_mul u_pb (.clk(clk), .a(mop_t'(e_s0[I2])), .b(mop_t'(b_s0[I1])), .p(pb[i]));
		efc_mul u_pbb (.clk(clk), .a(mop_t'(b_s0[i])), .b(mop_t'(b_s0[i])), .p(pbb[i]));

		efc_mul u_qa (.clk(clk), .a(mop_t'(b_s1[I1])), .b(mop_t'(c_s1[I2])), .p(qa[i]));
		efc_mul u_qb (.clk(clk), .a(mop_t'(b_s1[I2])), .b(mop_t'(c_s1[I1])), .p(qb[i]));
		efc_mul u_qcc (.clk(clk), .a(mop_t'(c_s1[i])), .b(mop_t'(c_s1[i])), .p(qcc[i]));

		efc_mul u_msq (.clk(clk), .a(mop_t'(n_s2[i])), .b(mop_t'(n_s2[i])), .p(msq[i]));

		assign lane_rt[0][i] = lane_s3[i];

		for (genvar j = 0; j < K; j++) begin : g_root
			efc_root_step u_step (
				.clk      (clk),
				.k        (KB'(K - 1 - j)),
				.d2       (d2_rt[j]),
				.lane_in  (lane_rt[j][i]),
				.lane_out (lane_rt[j+1][i])
			);
		end
	end

	efc_mul u_qbb (.clk(clk), .a(mop_t'(bb_s1)), .b(mop_t'(bb_s1)), .p(qbb));

endmodule
